// ===== rtl/trpd_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

package trpd_pkg;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PIXEL_BYTES  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLIP_Y       = 2'd3;

   localparam int BYTE_BITS  = 8;
   localparam int PIXEL_BITS = 32;
   localparam int RUN_BITS   = 8;
   localparam int COORD_BITS = 16;
   localparam int PB_BITS    = 3;

   // Packet header: top bit selects run, low bits hold count minus one.
   localparam int HDR_RUN_BIT = 7;

   localparam logic [PB_BITS-1:0] PB_MIN = 3'd1;
   localparam logic [PB_BITS-1:0] PB_MAX = 3'd4;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [RUN_BITS-1:0]   run_length;
      logic [COORD_BITS-1:0] dest_row;
      logic [COORD_BITS-1:0] dest_col;
      logic                  image_done;
   } rsp_type;

   // Bytes per pixel as used by the decoder: zero reads as one, above four as four.
   function automatic logic [PB_BITS-1:0] eff_pixel_bytes(input logic [PB_BITS-1:0] pb);
      logic [PB_BITS-1:0] r;
      if (pb == '0) begin
         r = PB_MIN;
      end else if (pb > PB_MAX) begin
         r = PB_MAX;
      end else begin
         r = pb;
      end
      return r;
   endfunction

endpackage

// ===== rtl/trpd_div.sv =====
// Iterative restoring divider for the row and column advance of long runs.
`timescale 1ns / 1ps

module trpd_div #(
   parameter int DIM_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIM_BITS:0]   dividend,
   input  logic [DIM_BITS-1:0] divisor,
   output logic                busy,
   output logic                done,
   output logic [DIM_BITS:0]   quot,
   output logic [DIM_BITS-1:0] remainder
);

   localparam int NB = DIM_BITS + 1;
   localparam int CW = $clog2(NB + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NB-1:0]     quo_ff, quo_in;
   logic [DIM_BITS-1:0] rem_ff, rem_in;
   logic [DIM_BITS-1:0] den_ff, den_in;
   logic [DIM_BITS:0]   trial;
   logic [DIM_BITS:0]   diff;

   assign trial = {rem_ff, quo_ff[NB-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(NB);
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIM_BITS-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial[DIM_BITS-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = run_ff | done_ff;
   assign done      = done_ff;
   assign quot      = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/trpd_geom.sv =====
// Geometry unit: image pixel total and pixels left, on one shared multiplier.
`timescale 1ns / 1ps

module trpd_geom #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIM_BITS-1:0]   width,
   input  logic [DIM_BITS-1:0]   height,
   input  logic [DIM_BITS-1:0]   row,
   input  logic [DIM_BITS-1:0]   col,
   output logic                  busy,
   output logic                  load,
   output logic [2*DIM_BITS-1:0] left,
   output logic [2*DIM_BITS-1:0] total
);

   localparam int LW = 2 * DIM_BITS;

   localparam logic [2:0] GS_IDLE = 3'd0;
   localparam logic [2:0] GS_TOT  = 3'd1;
   localparam logic [2:0] GS_PROD = 3'd2;
   localparam logic [2:0] GS_POS  = 3'd3;
   localparam logic [2:0] GS_LEFT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [LW-1:0]       mul_ff, mul_in;
   logic [LW-1:0]       total_ff, total_in;
   logic [LW:0]         pos_ff, pos_in;
   logic [DIM_BITS-1:0] mul_b;

   assign mul_b = (state_ff == GS_TOT) ? height : row;

   always_comb begin
      state_in = state_ff;
      mul_in   = LW'(width) * LW'(mul_b);
      total_in = total_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         GS_IDLE: state_in = GS_IDLE;
         GS_TOT:  state_in = GS_PROD;
         GS_PROD: begin
            total_in = mul_ff;
            state_in = GS_POS;
         end
         GS_POS: begin
            pos_in   = {1'b0, mul_ff} + (LW+1)'(col);
            state_in = GS_LEFT;
         end
         GS_LEFT: state_in = GS_IDLE;
         default: state_in = GS_IDLE;
      endcase
      if (start) begin
         state_in = GS_TOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mul_ff   <= mul_in;
      total_ff <= total_in;
      pos_ff   <= pos_in;
   end

   assign busy  = (state_ff != GS_IDLE);
   assign load  = (state_ff == GS_LEFT);
   assign left  = (pos_ff < {1'b0, total_ff}) ? (total_ff - pos_ff[LW-1:0]) : '0;
   assign total = total_ff;

endmodule

// ===== rtl/trpd_outq.sv =====
// Two-entry result queue between the decode state and the result channel.
`timescale 1ns / 1ps

module trpd_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  trpd_pkg::rsp_type push_data,
   input  logic              pop_ready,
   output logic              pop_valid,
   output trpd_pkg::rsp_type pop_data,
   output logic              full
);

   trpd_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop_valid = (cnt_ff != 2'd0);
   assign pop       = pop_valid & pop_ready;
   assign full      = (cnt_ff == 2'd2);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tga_rle_pixel_decoder_unit.sv =====
// Top level of the TGA run-length pixel decoder: packet state, pixel assembly, placement.
`timescale 1ns / 1ps

// Usage
//   req_ channel: one stream byte per transaction; req_start_image clears the decoder
//   state before that byte (so it is taken as the first packet header of a new image).
//   rsp_ channel: one transaction per completed pixel: value, run length, destination
//   row and column, and an image-done flag on the transaction holding the last pixel.
//   csr_ port: write-only; pixel bytes, width, height and flip_y, written between images.
// Timing and throughput
//   A result enters the result queue in the cycle after the byte that completes its
//   pixel. One byte per cycle is accepted while req_ready is high. A run whose end
//   passes the end of a row twice or more (column plus count at least twice the width)
//   engages the iterative divider unless it ends the image; req_ready is then low
//   until the divider is through. After reset and every csr_ write req_ready is low
//   while the geometry unit recomputes the image total and pixels left.
// Stalls
//   Results go through a two-entry queue; while it is full req_ready is low, so a
//   stalled receiver backs up into the byte stream without loss.

module tga_rle_pixel_decoder_unit #(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_start_image,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel,
   output logic [7:0]  rsp_run_length,
   output logic [15:0] rsp_dest_row,
   output logic [15:0] rsp_dest_col,
   output logic        rsp_image_done,
   input  logic        csr_wr_en,
   input  logic [trpd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [trpd_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int D  = DIM_BITS;
   localparam int LW = 2 * DIM_BITS;
   localparam int PW = trpd_pkg::PIXEL_BITS;
   localparam int RW = trpd_pkg::RUN_BITS;

   // configuration
   logic [trpd_pkg::PB_BITS-1:0]    cfg_pb_ff;
   logic [trpd_pkg::COORD_BITS-1:0] cfg_width_ff;
   logic [trpd_pkg::COORD_BITS-1:0] cfg_height_ff;
   logic                            cfg_flip_ff;
   logic                            pend_ff, pend_in;

   // decode state
   logic          exp_hdr_ff, exp_hdr_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic          is_run_ff, is_run_in;
   logic [1:0]    idx_ff, idx_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [D-1:0]  col_ff, col_in;
   logic [D-1:0]  row_ff, row_in;
   logic          fin_ff, fin_in;
   logic [LW-1:0] left_ff, left_in;

   // state after an optional start_image clear
   logic          s_exp, s_run, s_fin;
   logic [RW-1:0] s_rem;
   logic [1:0]    s_idx;
   logic [PW-1:0] s_acc;
   logic [D-1:0]  s_col, s_row;
   logic [LW-1:0] s_left;

   logic [D-1:0]  w_eff, h_eff, row_out;
   logic [trpd_pkg::PB_BITS-1:0] pb_eff;
   logic [PW-1:0] acc_new;
   logic [RW-1:0] cnt_raw, cnt_nz, cnt;
   logic          done_px;
   logic [D:0]    c_sum, c_sub;

   logic          accept;
   logic          busy;
   logic          q_full;
   logic          res_push;
   trpd_pkg::rsp_type res, q_head;

   logic          div_start, div_busy, div_done;
   logic [D:0]    div_quot;
   logic [D-1:0]  div_rem;

   logic          geom_start, geom_busy, geom_load;
   logic [LW-1:0] geom_left, geom_total;

   assign w_eff  = (cfg_width_ff[D-1:0] == '0) ? D'(1) : cfg_width_ff[D-1:0];
   assign h_eff  = (cfg_height_ff[D-1:0] == '0) ? D'(1) : cfg_height_ff[D-1:0];
   assign pb_eff = trpd_pkg::eff_pixel_bytes(cfg_pb_ff);

   assign busy       = pend_ff | geom_busy | div_busy;
   assign req_ready  = ~busy & ~q_full;
   assign accept     = req_valid & req_ready;
   assign geom_start = pend_ff & ~div_busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pb_ff     <= trpd_pkg::PB_MAX;
         cfg_width_ff  <= 16'd1;
         cfg_height_ff <= 16'd1;
         cfg_flip_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            trpd_pkg::CSR_PIXEL_BYTES:  cfg_pb_ff     <= csr_wdata[trpd_pkg::PB_BITS-1:0];
            trpd_pkg::CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata;
            trpd_pkg::CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata;
            trpd_pkg::CSR_FLIP_Y:       cfg_flip_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (geom_start) begin
         pend_in = 1'b0;
      end
      if (csr_wr_en) begin
         pend_in = 1'b1;
      end
   end

   always_comb begin
      // clear on start_image
      if (accept && req_start_image) begin
         s_exp  = 1'b1;
         s_rem  = '0;
         s_run  = 1'b0;
         s_idx  = '0;
         s_acc  = '0;
         s_col  = '0;
         s_row  = '0;
         s_fin  = 1'b0;
         s_left = geom_total;
      end else begin
         s_exp  = exp_hdr_ff;
         s_rem  = rem_ff;
         s_run  = is_run_ff;
         s_idx  = idx_ff;
         s_acc  = acc_ff;
         s_col  = col_ff;
         s_row  = row_ff;
         s_fin  = fin_ff;
         s_left = left_ff;
      end

      exp_hdr_in = s_exp;
      rem_in     = s_rem;
      is_run_in  = s_run;
      idx_in     = s_idx;
      acc_in     = s_acc;
      col_in     = s_col;
      row_in     = s_row;
      fin_in     = s_fin;
      left_in    = s_left;

      acc_new = s_acc | (PW'(req_byte_in) << {s_idx, 3'b000});
      cnt_raw = s_run ? s_rem : RW'(1);
      cnt_nz  = (cnt_raw == '0) ? RW'(1) : cnt_raw;
      cnt     = (LW'(cnt_nz) > s_left) ? s_left[RW-1:0] : cnt_nz;
      done_px = (LW'(cnt) == s_left);
      c_sum   = {1'b0, s_col} + (D+1)'(cnt);
      c_sub   = c_sum - {1'b0, w_eff};
      row_out = cfg_flip_ff ? (h_eff - D'(1) - s_row) : s_row;

      res_push   = 1'b0;
      res.pixel      = acc_new;
      res.run_length = cnt;
      res.dest_row   = trpd_pkg::COORD_BITS'(row_out);
      res.dest_col   = trpd_pkg::COORD_BITS'(s_col);
      res.image_done = done_px;
      div_start  = 1'b0;

      if (accept && !s_fin) begin
         if (s_exp) begin
            is_run_in  = req_byte_in[trpd_pkg::HDR_RUN_BIT];
            rem_in     = {1'b0, req_byte_in[trpd_pkg::HDR_RUN_BIT-1:0]} + RW'(1);
            exp_hdr_in = 1'b0;
            idx_in     = '0;
            acc_in     = '0;
         end else if (({1'b0, s_idx} + 3'd1) < pb_eff) begin
            idx_in = s_idx + 2'd1;
            acc_in = acc_new;
         end else begin
            idx_in = '0;
            acc_in = '0;
            if (cnt == '0) begin
               fin_in = 1'b1;
            end else begin
               res_push = 1'b1;
               left_in  = s_left - LW'(cnt);
               if (done_px) begin
                  fin_in = 1'b1;
               end
               if (c_sum < {1'b0, w_eff}) begin
                  col_in = c_sum[D-1:0];
               end else if (c_sum < {w_eff, 1'b0}) begin
                  col_in = c_sub[D-1:0];
                  row_in = s_row + D'(1);
               end else begin
                  // wraps past more than one row end
                  div_start = ~done_px;
               end
               if (s_run || s_rem <= RW'(1)) begin
                  rem_in = '0;
               end else begin
                  rem_in = s_rem - RW'(1);
               end
               if (rem_in == '0) begin
                  exp_hdr_in = 1'b1;
               end
            end
         end
      end

      if (div_done) begin
         row_in = row_ff + div_quot[D-1:0];
         col_in = div_rem;
      end
      if (geom_load) begin
         left_in = geom_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b1;
         exp_hdr_ff <= 1'b1;
         rem_ff     <= '0;
         is_run_ff  <= 1'b0;
         idx_ff     <= '0;
         acc_ff     <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         fin_ff     <= 1'b0;
         left_ff    <= '0;
      end else begin
         pend_ff    <= pend_in;
         exp_hdr_ff <= exp_hdr_in;
         rem_ff     <= rem_in;
         is_run_ff  <= is_run_in;
         idx_ff     <= idx_in;
         acc_ff     <= acc_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         fin_ff     <= fin_in;
         left_ff    <= left_in;
      end
   end

   trpd_div #(
      .DIM_BITS(DIM_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (c_sum),
      .divisor   (w_eff),
      .busy      (div_busy),
      .done      (div_done),
      .quot      (div_quot),
      .remainder (div_rem)
   );

   trpd_geom #(
      .DIM_BITS(DIM_BITS)
   ) u_geom (
      .clock  (clock),
      .reset  (reset),
      .start  (geom_start),
      .width  (w_eff),
      .height (h_eff),
      .row    (row_ff),
      .col    (col_ff),
      .busy   (geom_busy),
      .load   (geom_load),
      .left   (geom_left),
      .total  (geom_total)
   );

   trpd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .pop_ready (rsp_ready),
      .pop_valid (rsp_valid),
      .pop_data  (q_head),
      .full      (q_full)
   );

   assign rsp_pixel      = q_head.pixel;
   assign rsp_run_length = q_head.run_length;
   assign rsp_dest_row   = q_head.dest_row;
   assign rsp_dest_col   = q_head.dest_col;
   assign rsp_image_done = q_head.image_done;

   // a result flagged as the last pixel leaves the decoder finished
   assert property (@(posedge clock) disable iff (reset)
      res_push && res.image_done |=> fin_ff)
      else $error("decoder not finished after last pixel");

   // pixels left only shrink within an image
   assert property (@(posedge clock) disable iff (reset)
      accept && !req_start_image |=> left_ff <= $past(left_ff))
      else $error("pixels left grew without start_image");

   // divider is never restarted while it still owns row and column
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy && !geom_busy)
      else $error("divider started while busy");

endmodule
